FILE: rtl/sorted_interval_merge_core_assert.svh
// assertion macros for the sorted interval merge core
// used by rtl/sorted_interval_merge_core.sv, expects clk and rst_n in scope
`ifndef SORTED_INTERVAL_MERGE_CORE_ASSERT_SVH
`define SORTED_INTERVAL_MERGE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SIM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_interval_merge_core: assertion failed");
// next-cycle implication
`define SIM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_interval_merge_core: assertion failed");
`else
`define SIM_ASSERT_IMP(lbl, ante, cons)
`define SIM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/sim_pkg.sv
// shared types and constants of the sorted interval merge core
// no dependencies
`default_nettype none

package sim_pkg;

    // default key width and fixed width of the key ports
    localparam int KEY_WIDTH_DEF = 32;
    localparam int PORT_KEY_W    = 32;

    // result queue depth, room for two results of one word plus slack
    localparam int RES_DEPTH = 4;

    // config register word index (paddr[2])
    localparam logic REG_MERGE_ADJACENT = 1'b0;

    typedef enum logic [1:0] {
        KIND_SURVIVOR = 2'd0,
        KIND_PURGE    = 2'd1,
        KIND_CATCHALL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [PORT_KEY_W-1:0]   low;
        logic [PORT_KEY_W-1:0]   high;
        logic                    inst;
        logic                    fin;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_interval_merge_core.sv
// Sorted interval merger: takes one range word per cycle while in_stall is
// low, holds one open interval and emits survivors, purges of installed
// ranges and catch-all echoes. A word may cause up to two results (for
// example a merge plus the flush of a last word), and both are written into
// the queue together. Results wait in a four-entry result queue, and
// in_stall rises while fewer than two entries are free.
// Depends on sim_pkg and sorted_interval_merge_core_assert.svh.
`default_nettype none

module sorted_interval_merge_core #(
    parameter int KEY_WIDTH = sim_pkg::KEY_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input word
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] range_low,
    input  wire logic [31:0] range_high,
    input  wire logic        installed,
    input  wire logic        catch_all,
    input  wire logic        is_last,
    // result word
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [31:0]      out_low,
    output logic [31:0]      out_high,
    output logic             out_installed,
    output logic             final_res
);

    localparam int KW    = KEY_WIDTH;
    localparam int DEPTH = sim_pkg::RES_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = sim_pkg::PORT_KEY_W;

    // config register
    logic merge_adj_reg;

    // open interval state
    logic          open_valid_reg, open_valid_next;
    logic [KW-1:0] open_low_reg, open_low_next;
    logic [KW-1:0] open_high_reg, open_high_next;
    logic          open_inst_reg, open_inst_next;

    // result queue
    sim_pkg::res_t      res_q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic          acc, pop;
    logic [KW-1:0] lo_k, hi_k, adj_diff;
    logic          a_v, b_v;
    sim_pkg::res_t res_a, res_b, slot0, slot1;
    logic [1:0]    n_res;

    // apb access, word decode on paddr[2]
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sim_pkg::REG_MERGE_ADJACENT)
        begin
            prdata = {31'b0, merge_adj_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_adj_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == sim_pkg::REG_MERGE_ADJACENT)
        begin
            merge_adj_reg <= pwdata[0];
        end
    end

    // handshakes
    assign in_stall  = (cnt_reg > CNT_W'(DEPTH - 2));
    assign acc       = in_valid && !in_stall;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    // keys reduced to the key width
    assign lo_k     = KW'(range_low);
    assign hi_k     = KW'(range_high);
    assign adj_diff = lo_k - open_high_reg;

    // merge decision and result forming
    always_comb
    begin
        open_valid_next = open_valid_reg;
        open_low_next   = open_low_reg;
        open_high_next  = open_high_reg;
        open_inst_next  = open_inst_reg;
        a_v   = 1'b0;
        res_a = '{kind: sim_pkg::KIND_PURGE, low: PW'(lo_k), high: PW'(hi_k),
                  inst: 1'b1, fin: 1'b0};

        if (catch_all)
        begin
            a_v        = 1'b1;
            res_a.kind = sim_pkg::KIND_CATCHALL;
            res_a.inst = installed;
        end
        else if (!open_valid_reg)
        begin
            open_valid_next = 1'b1;
            open_low_next   = lo_k;
            open_high_next  = hi_k;
            open_inst_next  = installed;
        end
        else if (open_low_reg <= lo_k && open_high_reg >= hi_k)
        begin
            // contained: drop, purge if installed
            a_v = installed;
        end
        else if (lo_k <= open_high_reg || (merge_adj_reg && adj_diff == KW'(1)))
        begin
            // overlap or adjacency: extend the open interval
            if (open_inst_reg)
            begin
                a_v            = 1'b1;
                res_a.low      = PW'(open_low_reg);
                res_a.high     = PW'(open_high_reg);
                open_inst_next = installed;
            end
            else
            begin
                a_v = installed;
            end
            open_high_next = hi_k;
        end
        else
        begin
            // disjoint: close and reopen
            a_v        = 1'b1;
            res_a.kind = sim_pkg::KIND_SURVIVOR;
            res_a.low  = PW'(open_low_reg);
            res_a.high = PW'(open_high_reg);
            res_a.inst = open_inst_reg;
            open_low_next  = lo_k;
            open_high_next = hi_k;
            open_inst_next = installed;
        end

        // flush on last word
        b_v   = is_last && open_valid_next;
        res_b = '{kind: sim_pkg::KIND_SURVIVOR, low: PW'(open_low_next),
                  high: PW'(open_high_next), inst: open_inst_next, fin: 1'b1};
        if (is_last)
        begin
            open_valid_next = 1'b0;
            open_low_next   = '0;
            open_high_next  = '0;
            open_inst_next  = 1'b0;
        end

        // pack into queue slots, mark the last result
        res_a.fin = !b_v;
        n_res     = {1'b0, a_v} + {1'b0, b_v};
        slot0     = a_v ? res_a : res_b;
        slot1     = res_b;
    end

    // open interval registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_valid_reg <= 1'b0;
            open_low_reg   <= '0;
            open_high_reg  <= '0;
            open_inst_reg  <= 1'b0;
        end
        else if (acc)
        begin
            open_valid_reg <= open_valid_next;
            open_low_reg   <= open_low_next;
            open_high_reg  <= open_high_next;
            open_inst_reg  <= open_inst_next;
        end
    end

    // result queue pointers and count
    always_comb
    begin
        cnt_next = cnt_reg - CNT_W'(pop);
        if (acc)
        begin
            cnt_next = cnt_next + CNT_W'(n_res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (acc)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (acc && n_res != 2'd0)
        begin
            res_q_reg[wr_ptr_reg] <= slot0;
        end
        if (acc && n_res == 2'd2)
        begin
            res_q_reg[wr_ptr_reg + PTR_W'(1)] <= slot1;
        end
    end

    // result word
    assign kind          = res_q_reg[rd_ptr_reg].kind;
    assign out_low       = res_q_reg[rd_ptr_reg].low;
    assign out_high      = res_q_reg[rd_ptr_reg].high;
    assign out_installed = res_q_reg[rd_ptr_reg].inst;
    assign final_res     = res_q_reg[rd_ptr_reg].fin;

`include "sorted_interval_merge_core_assert.svh"

    // queue never overfills
    `SIM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    // an accepted word always finds room for two results
    `SIM_ASSERT_IMP(a_room_on_acc, acc, cnt_reg <= CNT_W'(DEPTH - 2))
    // a last word leaves no open interval behind
    `SIM_ASSERT_NXT(a_flush_clears, acc && is_last, !open_valid_reg)
    // write and read pointers stay a queue count apart
    `SIM_ASSERT_IMP(a_ptr_gap, 1'b1,
        (wr_ptr_reg - rd_ptr_reg) == PTR_W'(cnt_reg))

endmodule

`default_nettype wire
